// ----- rtl/core/aik_pkg.sv -----
`default_nettype none
package aik_pkg;

   localparam int CFG_W = 12;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_HEIGHT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHOULDER_OFFSET = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOOL_OFFSET = 2'd2;

   localparam logic [CFG_W-1:0] BASE_HEIGHT_RST = 12'd237;
   localparam logic [CFG_W-1:0] SHOULDER_OFFSET_RST = 12'd108;
   localparam logic [CFG_W-1:0] TOOL_OFFSET_RST = 12'd20;

   localparam int SQ_STEPS = 26;
   localparam int SQ_ROOT_W = SQ_STEPS;
   localparam int SQ_REM_W = 2 * SQ_STEPS + 2;

   localparam int CD_STEPS = 16;
   localparam int CD_W = 29;
   localparam int ANG_W = 20;
   localparam int CD_LANES = 4;

   localparam int LANE_TARGET = 0;
   localparam int LANE_REACH = 1;
   localparam int LANE_LIFT = 2;
   localparam int LANE_TOOL = 3;

   localparam logic signed [ANG_W-1:0] ANG_PI = 20'sd205887;
   localparam logic signed [ANG_W-1:0] ANG_PI_2 = 20'sd102944;

   typedef struct packed {
      logic [SQ_REM_W-1:0] rem;
      logic [SQ_ROOT_W-1:0] root;
   } sq_lane_type;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic dz_neg;
      logic [16:0] adz;
      logic unreach;
   } sq_side_type;

   typedef struct packed {
      logic signed [CD_W-1:0] x;
      logic signed [CD_W-1:0] y;
      logic signed [ANG_W-1:0] z;
      logic hold;
   } cd_lane_type;

   typedef cd_lane_type [CD_LANES-1:0] cd_row_type;

   typedef struct packed {
      logic dz_neg;
      logic [SQ_ROOT_W-1:0] e8;
      logic unreach;
   } cd_side_type;

   function automatic logic signed [ANG_W-1:0] atan_step(input int unsigned idx);
      logic signed [ANG_W-1:0] res;
      case (idx)
         0: res = 20'sd51472;
         1: res = 20'sd30386;
         2: res = 20'sd16055;
         3: res = 20'sd8150;
         4: res = 20'sd4091;
         5: res = 20'sd2047;
         6: res = 20'sd1024;
         7: res = 20'sd512;
         8: res = 20'sd256;
         9: res = 20'sd128;
         10: res = 20'sd64;
         11: res = 20'sd32;
         12: res = 20'sd16;
         13: res = 20'sd8;
         14: res = 20'sd4;
         default: res = 20'sd2;
      endcase
      return res;
   endfunction

   function automatic sq_lane_type sq_step(input sq_lane_type a, input int unsigned bit_idx);
      logic [SQ_REM_W-1:0] trial;
      logic [SQ_REM_W:0] diff;
      sq_lane_type res;
      trial = (SQ_REM_W'(a.root) << (bit_idx + 1)) | (SQ_REM_W'(1) << (2 * bit_idx));
      diff = {1'b0, a.rem} - {1'b0, trial};
      res = a;
      if (!diff[SQ_REM_W]) begin
         res.rem = diff[SQ_REM_W-1:0];
         res.root = a.root | (SQ_ROOT_W'(1) << bit_idx);
      end
      return res;
   endfunction

   function automatic cd_lane_type cd_prep(input logic signed [CD_W-1:0] vx,
                                           input logic signed [CD_W-1:0] vy);
      cd_lane_type res;
      res.x = vx;
      res.y = vy;
      res.z = '0;
      res.hold = 1'b0;
      if (vy == '0) begin
         res.hold = 1'b1;
         res.z = vx[CD_W-1] ? ANG_PI : '0;
      end else if (vx[CD_W-1]) begin
         res.z = vy[CD_W-1] ? -ANG_PI : ANG_PI;
         res.x = -vx;
         res.y = -vy;
      end
      return res;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/aik_sqrt_cell.sv -----
`default_nettype none
module aik_sqrt_cell import aik_pkg::*; #(
   parameter int unsigned BIT_IDX = 0
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic en,
   input wire logic src_valid,
   input wire sq_lane_type src_r,
   input wire sq_lane_type src_e,
   input wire sq_side_type src_side,
   output logic dst_valid,
   output sq_lane_type dst_r,
   output sq_lane_type dst_e,
   output sq_side_type dst_side
);

   logic valid_ff, valid_in;
   sq_lane_type r_ff, r_in;
   sq_lane_type e_ff, e_in;
   sq_side_type side_ff, side_in;

   always_comb begin
      valid_in = src_valid;
      r_in = sq_step(src_r, BIT_IDX);
      e_in = sq_step(src_e, BIT_IDX);
      side_in = src_side;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff <= r_in;
         e_ff <= e_in;
         side_ff <= side_in;
      end
   end

   assign dst_valid = valid_ff;
   assign dst_r = r_ff;
   assign dst_e = e_ff;
   assign dst_side = side_ff;

endmodule
`default_nettype wire

// ----- rtl/core/aik_cordic_cell.sv -----
`default_nettype none
module aik_cordic_cell import aik_pkg::*; #(
   parameter int unsigned STEP = 0
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic en,
   input wire logic src_valid,
   input wire cd_row_type src_lanes,
   input wire cd_side_type src_side,
   output logic dst_valid,
   output cd_row_type dst_lanes,
   output cd_side_type dst_side
);

   logic valid_ff, valid_in;
   cd_row_type lanes_ff, lanes_in;
   cd_side_type side_ff, side_in;

   always_comb begin
      logic signed [CD_W-1:0] cx;
      logic signed [CD_W-1:0] cy;
      logic signed [CD_W-1:0] dx;
      logic signed [CD_W-1:0] dy;
      valid_in = src_valid;
      side_in = src_side;
      for (int i = 0; i < CD_LANES; i++) begin
         cx = src_lanes[i].x;
         cy = src_lanes[i].y;
         dx = cy >>> STEP;
         dy = cx >>> STEP;
         lanes_in[i] = src_lanes[i];
         if (!src_lanes[i].hold) begin
            if (!cy[CD_W-1] && (cy != '0)) begin
               lanes_in[i].x = cx + dx;
               lanes_in[i].y = cy - dy;
               lanes_in[i].z = src_lanes[i].z + atan_step(STEP);
            end else begin
               lanes_in[i].x = cx - dx;
               lanes_in[i].y = cy + dy;
               lanes_in[i].z = src_lanes[i].z - atan_step(STEP);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lanes_ff <= lanes_in;
         side_ff <= side_in;
      end
   end

   assign dst_valid = valid_ff;
   assign dst_lanes = lanes_ff;
   assign dst_side = side_ff;

endmodule
`default_nettype wire

// ----- rtl/core/arm_inverse_kinematics.sv -----
`default_nettype none
// Channel     Direction  Handshake            Payload
// req_        in         req_valid/req_ready  target_x, target_y, target_z
// rsp_        out        rsp_valid/rsp_ready  base_angle, shoulder_angle, extension, unreachable
// csr_        in         csr_valid/csr_ready  csr_index, csr_wdata
//
// One transaction per cycle while the output is not stalled; from acceptance to rsp_valid
// a request passes 5 geometry stages, 26 root cells, 1 vector setup stage, 16 CORDIC cells
// and the output register. Most of that depth lies in the root and CORDIC cell chains.
// Synchronous active-high reset clears all valid flags and loads register defaults.
// A held result stalls the whole chain; a skid register keeps req_ready registered.
module arm_inverse_kinematics import aik_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   input wire logic signed [15:0] req_target_x,
   input wire logic signed [15:0] req_target_y,
   input wire logic signed [15:0] req_target_z,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output logic signed [15:0] rsp_base_angle,
   output logic signed [15:0] rsp_shoulder_angle,
   output logic [15:0] rsp_extension,
   output logic rsp_unreachable,
   input wire logic csr_valid,
   output logic csr_ready,
   input wire logic [CSR_IDX_W-1:0] csr_index,
   input wire logic [CFG_W-1:0] csr_wdata
);

   logic [CFG_W-1:0] base_height_ff, base_height_in;
   logic [CFG_W-1:0] shoulder_offset_ff, shoulder_offset_in;
   logic [CFG_W-1:0] tool_offset_ff, tool_offset_in;
   logic [15:0] d1, d2, d3;
   logic [31:0] d2sq_ff, d2sq_in;
   logic [31:0] d3sq_ff, d3sq_in;

   logic en;
   logic skid_valid_ff, skid_valid_in;
   logic signed [15:0] skid_x_ff, skid_x_in;
   logic signed [15:0] skid_y_ff, skid_y_in;
   logic signed [15:0] skid_z_ff, skid_z_in;
   logic head_valid;
   logic signed [15:0] head_x, head_y, head_z;

   logic signed [31:0] xx_full, yy_full;
   logic signed [35:0] dzsq_full;
   logic [32:0] rr_diff;
   logic [35:0] ee_diff;

   logic f1_valid_ff, f1_valid_in;
   logic signed [15:0] f1_x_ff, f1_x_in, f1_y_ff, f1_y_in;
   logic [30:0] f1_xx_ff, f1_xx_in, f1_yy_ff, f1_yy_in;
   logic signed [17:0] f1_dz_ff, f1_dz_in;

   logic f2_valid_ff, f2_valid_in;
   logic signed [15:0] f2_x_ff, f2_x_in, f2_y_ff, f2_y_in;
   logic signed [17:0] f2_dz_ff, f2_dz_in;
   logic [31:0] f2_ss_ff, f2_ss_in;
   logic [33:0] f2_dzsq_ff, f2_dzsq_in;

   logic f3_valid_ff, f3_valid_in;
   logic signed [15:0] f3_x_ff, f3_x_in, f3_y_ff, f3_y_in;
   logic signed [17:0] f3_dz_ff, f3_dz_in;
   logic [31:0] f3_rr_ff, f3_rr_in;
   logic [33:0] f3_dzsq_ff, f3_dzsq_in;
   logic f3_unr_ff, f3_unr_in;

   logic f4_valid_ff, f4_valid_in;
   logic signed [15:0] f4_x_ff, f4_x_in, f4_y_ff, f4_y_in;
   logic signed [17:0] f4_dz_ff, f4_dz_in;
   logic [31:0] f4_rr_ff, f4_rr_in;
   logic [34:0] f4_hh_ff, f4_hh_in;
   logic f4_unr_ff, f4_unr_in;

   logic f5_valid_ff, f5_valid_in;
   logic signed [15:0] f5_x_ff, f5_x_in, f5_y_ff, f5_y_in;
   logic signed [17:0] f5_dz_ff, f5_dz_in;
   logic [31:0] f5_rr_ff, f5_rr_in;
   logic [34:0] f5_ee_ff, f5_ee_in;
   logic f5_unr_ff, f5_unr_in;

   logic [SQ_STEPS:0] sq_valid;
   sq_lane_type sq_r [SQ_STEPS+1];
   sq_lane_type sq_e [SQ_STEPS+1];
   sq_side_type sq_side [SQ_STEPS+1];

   logic [CD_STEPS:0] cd_valid;
   cd_row_type cd_lanes [CD_STEPS+1];
   cd_side_type cd_side [CD_STEPS+1];

   logic cd_valid_ff, cd_valid_in;
   cd_row_type cd_lanes_ff, cd_lanes_in;
   cd_side_type cd_side_ff, cd_side_in;

   logic signed [21:0] t1, t2, up, t1_rnd, t2_rnd;
   logic [26:0] e8_rnd;
   logic [18:0] ext_full;
   cd_side_type fin_side;
   cd_row_type fin_lanes;

   logic rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_base_angle_ff, rsp_base_angle_in;
   logic signed [15:0] rsp_shoulder_angle_ff, rsp_shoulder_angle_in;
   logic [15:0] rsp_extension_ff, rsp_extension_in;
   logic rsp_unreachable_ff, rsp_unreachable_in;

   // configuration registers
   always_comb begin
      base_height_in = base_height_ff;
      shoulder_offset_in = shoulder_offset_ff;
      tool_offset_in = tool_offset_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_BASE_HEIGHT: base_height_in = csr_wdata;
            CSR_SHOULDER_OFFSET: shoulder_offset_in = csr_wdata;
            CSR_TOOL_OFFSET: tool_offset_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_height_ff <= BASE_HEIGHT_RST;
         shoulder_offset_ff <= SHOULDER_OFFSET_RST;
         tool_offset_ff <= TOOL_OFFSET_RST;
      end else begin
         base_height_ff <= base_height_in;
         shoulder_offset_ff <= shoulder_offset_in;
         tool_offset_ff <= tool_offset_in;
      end
   end

   assign csr_ready = 1'b1;
   assign d1 = {base_height_ff, 4'b0};
   assign d2 = {shoulder_offset_ff, 4'b0};
   assign d3 = {tool_offset_ff, 4'b0};
   assign d2sq_in = d2 * d2;
   assign d3sq_in = d3 * d3;

   always_ff @(posedge clock) begin
      d2sq_ff <= d2sq_in;
      d3sq_ff <= d3sq_in;
   end

   // input skid
   assign en = !rsp_valid_ff || rsp_ready;
   assign req_ready = !skid_valid_ff;
   assign head_valid = skid_valid_ff || req_valid;
   assign head_x = skid_valid_ff ? skid_x_ff : req_target_x;
   assign head_y = skid_valid_ff ? skid_y_ff : req_target_y;
   assign head_z = skid_valid_ff ? skid_z_ff : req_target_z;

   always_comb begin
      skid_valid_in = skid_valid_ff;
      skid_x_in = skid_x_ff;
      skid_y_in = skid_y_ff;
      skid_z_in = skid_z_ff;
      if (en) begin
         skid_valid_in = 1'b0;
      end else if (req_valid && req_ready) begin
         skid_valid_in = 1'b1;
         skid_x_in = req_target_x;
         skid_y_in = req_target_y;
         skid_z_in = req_target_z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else begin
         skid_valid_ff <= skid_valid_in;
      end
      skid_x_ff <= skid_x_in;
      skid_y_ff <= skid_y_in;
      skid_z_ff <= skid_z_in;
   end

   // geometry stages
   assign xx_full = head_x * head_x;
   assign yy_full = head_y * head_y;
   assign dzsq_full = f1_dz_ff * f1_dz_ff;
   assign rr_diff = {1'b0, f2_ss_ff} - {1'b0, d2sq_ff};
   assign ee_diff = {1'b0, f4_hh_ff} - {4'b0, d3sq_ff};

   always_comb begin
      f1_valid_in = head_valid;
      f1_x_in = head_x;
      f1_y_in = head_y;
      f1_xx_in = xx_full[30:0];
      f1_yy_in = yy_full[30:0];
      f1_dz_in = $signed({2'b0, d1}) - 18'(head_z);

      f2_valid_in = f1_valid_ff;
      f2_x_in = f1_x_ff;
      f2_y_in = f1_y_ff;
      f2_dz_in = f1_dz_ff;
      f2_ss_in = 32'(f1_xx_ff) + 32'(f1_yy_ff);
      f2_dzsq_in = dzsq_full[33:0];

      f3_valid_in = f2_valid_ff;
      f3_x_in = f2_x_ff;
      f3_y_in = f2_y_ff;
      f3_dz_in = f2_dz_ff;
      f3_rr_in = rr_diff[31:0];
      f3_dzsq_in = f2_dzsq_ff;
      f3_unr_in = rr_diff[32];

      f4_valid_in = f3_valid_ff;
      f4_x_in = f3_x_ff;
      f4_y_in = f3_y_ff;
      f4_dz_in = f3_dz_ff;
      f4_rr_in = f3_rr_ff;
      f4_hh_in = 35'(f3_rr_ff) + 35'(f3_dzsq_ff);
      f4_unr_in = f3_unr_ff;

      f5_valid_in = f4_valid_ff;
      f5_x_in = f4_x_ff;
      f5_y_in = f4_y_ff;
      f5_dz_in = f4_dz_ff;
      f5_rr_in = f4_rr_ff;
      f5_ee_in = ee_diff[34:0];
      f5_unr_in = f4_unr_ff || ee_diff[35];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
         f3_valid_ff <= 1'b0;
         f4_valid_ff <= 1'b0;
         f5_valid_ff <= 1'b0;
      end else if (en) begin
         f1_valid_ff <= f1_valid_in;
         f2_valid_ff <= f2_valid_in;
         f3_valid_ff <= f3_valid_in;
         f4_valid_ff <= f4_valid_in;
         f5_valid_ff <= f5_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f1_x_ff <= f1_x_in;
         f1_y_ff <= f1_y_in;
         f1_xx_ff <= f1_xx_in;
         f1_yy_ff <= f1_yy_in;
         f1_dz_ff <= f1_dz_in;
         f2_x_ff <= f2_x_in;
         f2_y_ff <= f2_y_in;
         f2_dz_ff <= f2_dz_in;
         f2_ss_ff <= f2_ss_in;
         f2_dzsq_ff <= f2_dzsq_in;
         f3_x_ff <= f3_x_in;
         f3_y_ff <= f3_y_in;
         f3_dz_ff <= f3_dz_in;
         f3_rr_ff <= f3_rr_in;
         f3_dzsq_ff <= f3_dzsq_in;
         f3_unr_ff <= f3_unr_in;
         f4_x_ff <= f4_x_in;
         f4_y_ff <= f4_y_in;
         f4_dz_ff <= f4_dz_in;
         f4_rr_ff <= f4_rr_in;
         f4_hh_ff <= f4_hh_in;
         f4_unr_ff <= f4_unr_in;
         f5_x_ff <= f5_x_in;
         f5_y_ff <= f5_y_in;
         f5_dz_ff <= f5_dz_in;
         f5_rr_ff <= f5_rr_in;
         f5_ee_ff <= f5_ee_in;
         f5_unr_ff <= f5_unr_in;
      end
   end

   // root chain, one result bit per cell
   assign sq_valid[0] = f5_valid_ff;
   assign sq_r[0] = {SQ_REM_W'({f5_rr_ff, 16'b0}), SQ_ROOT_W'(0)};
   assign sq_e[0] = {SQ_REM_W'({f5_ee_ff, 16'b0}), SQ_ROOT_W'(0)};
   assign sq_side[0] = {f5_x_ff, f5_y_ff, f5_dz_ff[17],
                        f5_dz_ff[17] ? 17'(-f5_dz_ff) : f5_dz_ff[16:0], f5_unr_ff};

   for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sq
      aik_sqrt_cell #(
         .BIT_IDX(SQ_ROOT_W - 1 - g)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .en(en),
         .src_valid(sq_valid[g]),
         .src_r(sq_r[g]),
         .src_e(sq_e[g]),
         .src_side(sq_side[g]),
         .dst_valid(sq_valid[g+1]),
         .dst_r(sq_r[g+1]),
         .dst_e(sq_e[g+1]),
         .dst_side(sq_side[g+1])
      );
   end

   // vector setup
   always_comb begin
      cd_valid_in = sq_valid[SQ_STEPS];
      cd_lanes_in[LANE_TARGET] = cd_prep(
         {{(CD_W-24){sq_side[SQ_STEPS].x[15]}}, sq_side[SQ_STEPS].x, 8'b0},
         {{(CD_W-24){sq_side[SQ_STEPS].y[15]}}, sq_side[SQ_STEPS].y, 8'b0});
      cd_lanes_in[LANE_REACH] = cd_prep($signed(CD_W'({d2, 8'b0})),
                                        $signed(CD_W'(sq_r[SQ_STEPS].root)));
      cd_lanes_in[LANE_LIFT] = cd_prep($signed(CD_W'(sq_r[SQ_STEPS].root)),
                                       $signed(CD_W'({sq_side[SQ_STEPS].adz, 8'b0})));
      cd_lanes_in[LANE_TOOL] = cd_prep($signed(CD_W'(sq_e[SQ_STEPS].root)),
                                       $signed(CD_W'({d3, 8'b0})));
      cd_side_in.dz_neg = sq_side[SQ_STEPS].dz_neg;
      cd_side_in.e8 = sq_e[SQ_STEPS].root;
      cd_side_in.unreach = sq_side[SQ_STEPS].unreach;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cd_valid_ff <= 1'b0;
      end else if (en) begin
         cd_valid_ff <= cd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cd_lanes_ff <= cd_lanes_in;
         cd_side_ff <= cd_side_in;
      end
   end

   assign cd_valid[0] = cd_valid_ff;
   assign cd_lanes[0] = cd_lanes_ff;
   assign cd_side[0] = cd_side_ff;

   // CORDIC chain, four vectors side by side
   for (genvar g = 0; g < CD_STEPS; g++) begin : g_cd
      aik_cordic_cell #(
         .STEP(g)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .en(en),
         .src_valid(cd_valid[g]),
         .src_lanes(cd_lanes[g]),
         .src_side(cd_side[g]),
         .dst_valid(cd_valid[g+1]),
         .dst_lanes(cd_lanes[g+1]),
         .dst_side(cd_side[g+1])
      );
   end

   // angle sums, rounding and output register
   assign fin_lanes = cd_lanes[CD_STEPS];
   assign fin_side = cd_side[CD_STEPS];

   always_comb begin
      t1 = 22'(fin_lanes[LANE_TARGET].z) + 22'(fin_lanes[LANE_REACH].z) - 22'(ANG_PI_2);
      up = fin_side.dz_neg ? -22'(fin_lanes[LANE_LIFT].z) : 22'(fin_lanes[LANE_LIFT].z);
      t2 = up - 22'(fin_lanes[LANE_TOOL].z);
      t1_rnd = t1 + 22'sd8;
      t2_rnd = t2 + 22'sd8;
      e8_rnd = {1'b0, fin_side.e8} + 27'd128;
      ext_full = e8_rnd[26:8];

      rsp_valid_in = cd_valid[CD_STEPS];
      rsp_unreachable_in = fin_side.unreach;
      rsp_base_angle_in = t1_rnd[19:4];
      rsp_shoulder_angle_in = t2_rnd[19:4];
      rsp_extension_in = (|ext_full[18:16]) ? 16'hFFFF : ext_full[15:0];
      if (fin_side.unreach) begin
         rsp_base_angle_in = '0;
         rsp_shoulder_angle_in = '0;
         rsp_extension_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_base_angle_ff <= rsp_base_angle_in;
         rsp_shoulder_angle_ff <= rsp_shoulder_angle_in;
         rsp_extension_ff <= rsp_extension_in;
         rsp_unreachable_ff <= rsp_unreachable_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_base_angle = rsp_base_angle_ff;
   assign rsp_shoulder_angle = rsp_shoulder_angle_ff;
   assign rsp_extension = rsp_extension_ff;
   assign rsp_unreachable = rsp_unreachable_ff;

endmodule
`default_nettype wire
